// ===== rtl/cpr_pkg.sv =====
// Shared constants and types for the clock page replacement block.
// No dependencies; imported by cpr_match and clock_page_replacement.
`default_nettype none

package cpr_pkg;

  // Policy geometry
  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;

  // Derived widths
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int COUNT_W = $clog2(FRAMES + 1);
  localparam int PAGE_W  = (PAGE_BITS < 16) ? PAGE_BITS : 16;

  // Configuration port: one 32-bit register per word
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAMES_IN_USE
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP
  } state_t;

  // Result of the associative lookup
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } match_t;

endpackage

`default_nettype wire

// ===== rtl/cpr_match.sv =====
// Associative lookup of a page among the resident frames.
// Depends on cpr_pkg; reports the lowest matching loaded frame below the active count.
`default_nettype none

module cpr_match (
  input  wire logic [cpr_pkg::PAGE_W-1:0]  page,
  input  wire logic [cpr_pkg::PAGE_W-1:0]  pages [cpr_pkg::FRAMES],
  input  wire logic [cpr_pkg::FRAMES-1:0]  loaded,
  input  wire logic [cpr_pkg::COUNT_W-1:0] active,
  output cpr_pkg::match_t                  result
);
  import cpr_pkg::*;

  // Scan from the top down so the lowest matching frame wins
  always_comb begin
    result.hit   = 1'b0;
    result.frame = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (loaded[i] && (pages[i] == page) && (COUNT_W'(i) < active)) begin
        result.hit   = 1'b1;
        result.frame = FRAME_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clock_page_replacement.sv =====
// Clock (second chance) page replacement. Hits and fill misses commit from the search
// state; a replacement miss sweeps the hand, clearing set reference bits, to a clear one.
// A new reference is taken only after the last one commits; commits wait for a free
// result register. The sweep steps one frame per cycle through the single bit test/clear
// unit. Reset (rst, synchronous): frames unloaded, reference bits, hand, fill and fault
// counts cleared, frames_in_use = 16. Page store is not cleared.
`default_nettype none

module clock_page_replacement (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cpr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // page reference channel
  input  wire logic                         page_valid,
  output logic                              page_ready,
  input  wire logic [15:0]                  page_number,
  // result channel
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic                              hit,
  output logic [3:0]                        frame_index,
  output logic                              evicted_valid,
  output logic [15:0]                       evicted_page,
  output logic [31:0]                       fault_total
);
  import cpr_pkg::*;

  // Sequencer
  state_t state, state_next;

  // Configuration
  logic [CFG_W-1:0]   frames_in_use;
  logic [COUNT_W-1:0] active;
  reg_idx_t           cfg_idx;
  logic               cfg_write;

  // Policy state
  logic [PAGE_W-1:0]  resident_page [FRAMES];
  logic [FRAMES-1:0]  frame_loaded;
  logic [FRAMES-1:0]  reference_bit;
  logic [FRAME_W-1:0] clock_hand;
  logic [COUNT_W-1:0] fill_count;
  logic [31:0]        fault_counter;
  logic [31:0]        fault_counter_next;

  // Working registers for the transaction in flight
  logic [PAGE_W-1:0]  cur_page;
  logic [FRAME_W-1:0] sweep_hand;

  // Datapath helpers
  match_t             match;
  logic               out_free;
  logic               filling;
  logic               victim_found;
  logic [FRAME_W-1:0] hand_start;
  logic [COUNT_W-1:0] sweep_inc;
  logic [FRAME_W-1:0] sweep_wrap;
  logic [FRAME_W-1:0] fill_frame;

  // Sequencer strobes
  logic commit_hit, commit_fill, commit_victim, sweep_start, sweep_clear;

  // ---------------------------------------------------------------------------
  // Configuration register: decode word index, ignore byte offset
  // ---------------------------------------------------------------------------
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_FRAMES_IN_USE: prdata = 32'(frames_in_use);
      default:           prdata = '0;
    endcase
  end

  // Clamp the frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      active = COUNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      active = COUNT_W'(FRAMES);
    end else begin
      active = COUNT_W'(frames_in_use);
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup, fill and sweep helpers
  // ---------------------------------------------------------------------------
  cpr_match u_match (
    .page   (cur_page),
    .pages  (resident_page),
    .loaded (frame_loaded),
    .active (active),
    .result (match)
  );

  // The result register can take a new result when empty or draining this cycle
  assign out_free = !result_valid || result_ready;

  assign filling    = fill_count < active;
  assign fill_frame = FRAME_W'(fill_count);

  // A hand left beyond a shrunken frame count restarts at frame zero
  assign hand_start = (COUNT_W'(clock_hand) < active) ? clock_hand : '0;

  // Shared step unit: test the bit under the sweep hand and compute the wrapped successor
  assign victim_found = !reference_bit[sweep_hand];
  assign sweep_inc    = COUNT_W'(sweep_hand) + COUNT_W'(1);
  assign sweep_wrap   = (sweep_inc < active) ? FRAME_W'(sweep_inc) : '0;

  assign fault_counter_next = (fault_counter == '1) ? fault_counter : fault_counter + 32'd1;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (page_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (match.hit || filling) begin
          if (out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (victim_found && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    page_ready    = 1'b0;
    commit_hit    = 1'b0;
    commit_fill   = 1'b0;
    commit_victim = 1'b0;
    sweep_start   = 1'b0;
    sweep_clear   = 1'b0;
    case (state)
      ST_IDLE: begin
        page_ready = 1'b1;
      end
      ST_SEARCH: begin
        // A hit or fill holds in place until the result register can take the outcome
        if (match.hit) begin
          commit_hit = out_free;
        end else if (filling) begin
          commit_fill = out_free;
        end else begin
          sweep_start = 1'b1;
        end
      end
      ST_SWEEP: begin
        // Clear a set bit and advance, or replace the frame with a clear bit
        if (victim_found) begin
          commit_victim = out_free;
        end else begin
          sweep_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= FRAMES_IN_USE_RST;
      frame_loaded  <= '0;
      reference_bit <= '0;
      clock_hand    <= '0;
      fill_count    <= '0;
      fault_counter <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write && (cfg_idx == REG_FRAMES_IN_USE)) begin
        frames_in_use <= pwdata[CFG_W-1:0];
      end

      // Raise the result on a commit, drop it once taken
      if (commit_hit || commit_fill || commit_victim) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (commit_hit) begin
        reference_bit[match.frame] <= 1'b1;
      end

      if (commit_fill) begin
        frame_loaded[fill_frame]  <= 1'b1;
        reference_bit[fill_frame] <= 1'b0;
        fill_count                <= fill_count + COUNT_W'(1);
        fault_counter             <= fault_counter_next;
      end

      if (sweep_clear) begin
        reference_bit[sweep_hand] <= 1'b0;
      end

      if (commit_victim) begin
        frame_loaded[sweep_hand]  <= 1'b1;
        reference_bit[sweep_hand] <= 1'b0;
        clock_hand                <= sweep_wrap;
        fault_counter             <= fault_counter_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: page store, working registers and result fields
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (page_valid && page_ready) begin
      cur_page <= PAGE_W'(page_number);
    end

    if (sweep_start) begin
      sweep_hand <= hand_start;
    end else if (sweep_clear) begin
      sweep_hand <= sweep_wrap;
    end

    if (commit_hit) begin
      hit           <= 1'b1;
      frame_index   <= 4'(match.frame);
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
    end

    if (commit_fill) begin
      resident_page[fill_frame] <= cur_page;
      hit                       <= 1'b0;
      frame_index               <= 4'(fill_frame);
      evicted_valid             <= 1'b0;
      evicted_page              <= '0;
    end

    if (commit_victim) begin
      resident_page[sweep_hand] <= cur_page;
      hit                       <= 1'b0;
      frame_index               <= 4'(sweep_hand);
      evicted_valid             <= 1'b1;
      evicted_page              <= 16'(resident_page[sweep_hand]);
    end
  end

  // The fault count only moves on a commit, which needs the result register free
  assign fault_total = fault_counter;

endmodule

`default_nettype wire

// ===== rtl/cpr_check.sv =====
// Port-level checks for the clock page replacement block.
// Depends on the top level's ports only; bound to clock_page_replacement below.
`default_nettype none

module cpr_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        page_valid,
  input wire logic        page_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic        hit,
  input wire logic        evicted_valid,
  input wire logic [15:0] evicted_page,
  input wire logic [31:0] fault_total
);

  // The result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // One transaction at a time: the block goes busy after accepting a reference
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (page_valid && page_ready) |=> !page_ready)
    else $error("reference accepted while busy");

  // A hit never evicts, and a result without an eviction reports a zero page field
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!(hit && evicted_valid) && (evicted_valid || evicted_page == 16'd0)))
    else $error("inconsistent eviction report");

  // A stalled result holds its fault count
  a_fault_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(fault_total))
    else $error("fault count moved under a stalled result");

endmodule

bind clock_page_replacement cpr_check u_cpr_check (
  .clk           (clk),
  .rst           (rst),
  .page_valid    (page_valid),
  .page_ready    (page_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_total   (fault_total)
);

`default_nettype wire
